// ===== rtl/rate_monotonic_scheduler_macros.svh =====
// Assertion helpers used by the scheduler RTL.
`ifndef RATE_MONOTONIC_SCHEDULER_MACROS_SVH
`define RATE_MONOTONIC_SCHEDULER_MACROS_SVH

// same-cycle implication
`define RMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rms_pkg.sv =====
package rms_pkg;
    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int ID_W   = 22;
    localparam int PER_W  = 20;
    localparam int COMP_W = 20;
    localparam int TICK_W = 32;
    localparam int LIM_W  = 10;
    localparam int UTIL_W = 16;
    localparam int SCALE_W = 10;
    localparam int PROD_W  = COMP_W + SCALE_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    localparam logic [SCALE_W-1:0] UTIL_SCALE = SCALE_W'(1000);
    localparam logic [LIM_W-1:0]   LIMIT_RESET = LIM_W'(693);

    localparam logic [2:0] FN_ADMIT      = 3'd0;
    localparam logic [2:0] FN_REGISTER   = 3'd1;
    localparam logic [2:0] FN_DEREGISTER = 3'd2;
    localparam logic [2:0] FN_YIELD      = 3'd3;
    localparam logic [2:0] FN_WAKEUP     = 3'd4;
    localparam logic [2:0] FN_DISPATCH   = 3'd5;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_REJECTED  = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    localparam logic [1:0] TS_SLEEPING = 2'd0;
    localparam logic [1:0] TS_READY    = 2'd1;
    localparam logic [1:0] TS_RUNNING  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PER_W-1:0]  period;
        logic [COMP_W-1:0] comp;
        logic [1:0]        tstate;
        logic [TICK_W-1:0] rel_tick;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;
endpackage

// ===== rtl/rms_ram.sv =====
module rms_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rms_div.sv =====
module rms_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [rms_pkg::PROD_W-1:0] i_dividend,
    input  logic [rms_pkg::PER_W-1:0]  i_divisor,
    output logic                    o_done,
    output logic [rms_pkg::PROD_W-1:0] o_quot
);
    import rms_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PER_W-1:0]     r_rem;
    logic [PER_W-1:0]     r_dvs;
    logic [PROD_W-1:0]    r_quo;
    logic [PER_W:0]       trial;
    logic                 step_bit;
    logic [PER_W-1:0]     step_rem;

    // restoring, one quotient bit a cycle
    always_comb begin
        trial    = {r_rem, r_quo[PROD_W-1]};
        step_bit = (trial >= {1'b0, r_dvs});
        step_rem = step_bit ? PER_W'(trial - {1'b0, r_dvs}) : PER_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= step_rem;
                r_quo <= {r_quo[PROD_W-2:0], step_bit};
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ===== rtl/rate_monotonic_scheduler.sv =====
// Admit runs one 30-bit divide per term (the candidate, then each entry), a quotient bit
//   a cycle; register writes the next free slot; lookups and dispatch read entries one by one,
//   and deregister also shifts each later entry down a slot; dispatch writes again on a switch.
// One item at a time: the next is taken the cycle after the result is registered; a result
//   held by the receiver stalls the input.
// Reset (synchronous, active low): empty table, no running task, limit 693.
module rate_monotonic_scheduler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_func,
    input  logic [rms_pkg::ID_W-1:0]    i_task_id,
    input  logic [rms_pkg::PER_W-1:0]   i_task_period,
    input  logic [rms_pkg::COMP_W-1:0]  i_task_computation,
    input  logic [rms_pkg::TICK_W-1:0]  i_now_ticks,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic                        o_running_valid,
    output logic [rms_pkg::ID_W-1:0]    o_running_id,
    output logic                        o_switched,
    output logic                        o_preempted,
    output logic [rms_pkg::ID_W-1:0]    o_preempted_id,
    output logic                        o_arm_timer,
    output logic [rms_pkg::TICK_W-1:0]  o_timer_expiry,
    output logic [rms_pkg::UTIL_W-1:0]  o_utilization_total,
    // limit register write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rms_pkg::LIM_W-1:0]   i_cfg_data
);
    import rms_pkg::*;
    `include "rate_monotonic_scheduler_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_DST, S_DWT, S_RD, S_WT, S_EV,
        S_SH_RD, S_SH_WT, S_SH_WR, S_DSP, S_DSP2, S_FIN
    } t_fsm;

    t_fsm r_fsm;

    // table bookkeeping: valid entries are always the prefix [0, r_count)
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [SLOT_W-1:0] r_run_slot;
    logic              r_run_pres;
    logic [ID_W-1:0]   r_run_id;
    logic [LIM_W-1:0]  r_limit;

    // latched command
    logic [2:0]        r_func;
    logic [ID_W-1:0]   r_id;
    logic [TICK_W-1:0] r_now;

    // working results
    logic [1:0]        r_status;
    logic              r_sw;
    logic              r_pre;
    logic [ID_W-1:0]   r_pre_id;
    logic              r_arm;
    logic [TICK_W-1:0] r_exp;
    logic [UTIL_W-1:0] r_sum;

    // dispatch scan
    logic              r_cand_ok;
    logic [SLOT_W-1:0] r_cand_slot;
    t_entry            r_cand_ent;
    t_entry            r_run_ent;

    // admit arithmetic
    logic [PROD_W-1:0] r_prod;
    logic [PER_W-1:0]  r_dvs;

    // memory port registers
    logic              r_we;
    logic [SLOT_W-1:0] r_waddr;
    t_entry            r_wdata;
    logic [SLOT_W-1:0] r_raddr;
    logic [ENTRY_W-1:0] rdata_raw;
    t_entry            e;

    // output register
    logic              r_ov;
    logic [1:0]        r_o_status;
    logic              r_o_run_v;
    logic [ID_W-1:0]   r_o_run_id;
    logic              r_o_sw;
    logic              r_o_pre;
    logic [ID_W-1:0]   r_o_pre_id;
    logic              r_o_arm;
    logic [TICK_W-1:0] r_o_exp;
    logic [UTIL_W-1:0] r_o_util;

    t_div_ctl          div_ctl;
    logic [PROD_W-1:0] quot;

    logic              runp;
    logic              accept;
    logic              more;
    logic [UTIL_W-1:0] term16;
    logic [UTIL_W:0]   add_sum;
    logic [UTIL_W-1:0] n_sum;

    rms_ram #(.DATA_W(ENTRY_W), .ADDR_W(SLOT_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_raddr (r_raddr),
        .o_rdata (rdata_raw)
    );

    assign div_ctl.start = (r_fsm == S_DST);

    rms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_ctl.start),
        .i_dividend (r_prod),
        .i_divisor  (r_dvs),
        .o_done     (div_ctl.done),
        .o_quot     (quot)
    );

    always_comb begin
        e       = t_entry'(rdata_raw);
        // running slot only counts while it points inside the table
        runp    = r_run_pres && ({1'b0, r_run_slot} < r_count);
        accept  = i_valid && o_ready;
        more    = ((r_idx + CNT_W'(1)) < r_count);
        // saturating per-mille accumulate
        term16  = (|quot[PROD_W-1:UTIL_W]) ? {UTIL_W{1'b1}} : quot[UTIL_W-1:0];
        add_sum = {1'b0, r_sum} + {1'b0, term16};
        n_sum   = add_sum[UTIL_W] ? {UTIL_W{1'b1}} : add_sum[UTIL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm      <= S_IDLE;
            r_count    <= '0;
            r_run_slot <= '0;
            r_run_pres <= 1'b0;
            r_limit    <= LIMIT_RESET;
            r_we       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end

            case (r_fsm)
                S_IDLE: begin
                    if (accept) begin
                        r_func    <= i_func;
                        r_id      <= i_task_id;
                        r_now     <= i_now_ticks;
                        r_status  <= STS_OK;
                        r_sw      <= 1'b0;
                        r_pre     <= 1'b0;
                        r_pre_id  <= '0;
                        r_arm     <= 1'b0;
                        r_exp     <= '0;
                        r_sum     <= '0;
                        r_cand_ok <= 1'b0;
                        r_idx     <= '0;
                        r_fsm     <= S_FIN;
                        r_run_pres <= runp;
                        case (i_func)
                            FN_ADMIT: begin
                                // candidate term first
                                r_prod <= PROD_W'(i_task_computation * UTIL_SCALE);
                                r_dvs  <= (i_task_period == '0) ? PER_W'(1) : i_task_period;
                                r_fsm  <= S_DST;
                            end
                            FN_REGISTER: begin
                                if (r_count == CNT_W'(MAX_TASKS)) begin
                                    r_status <= STS_FULL;
                                end else begin
                                    r_we             <= 1'b1;
                                    r_waddr          <= r_count[SLOT_W-1:0];
                                    r_wdata.id       <= i_task_id;
                                    r_wdata.period   <= i_task_period;
                                    r_wdata.comp     <= i_task_computation;
                                    r_wdata.tstate   <= TS_SLEEPING;
                                    r_wdata.rel_tick <= i_now_ticks + TICK_W'(i_task_period);
                                    r_count          <= r_count + CNT_W'(1);
                                end
                            end
                            FN_DEREGISTER, FN_WAKEUP, FN_YIELD: begin
                                if (r_count == '0) begin
                                    r_status <= STS_NOT_FOUND;
                                end else begin
                                    r_fsm <= S_RD;
                                    // yield on the running task goes straight to its slot
                                    if (i_func == FN_YIELD && runp && r_run_id == i_task_id) begin
                                        r_idx <= {1'b0, r_run_slot};
                                    end
                                end
                            end
                            FN_DISPATCH: begin
                                if (r_count != '0) begin
                                    r_fsm <= S_RD;
                                end
                            end
                            default: begin
                                r_fsm <= S_FIN;
                            end
                        endcase
                    end
                end

                S_DST: begin
                    r_fsm <= S_DWT;
                end

                S_DWT: begin
                    if (div_ctl.done) begin
                        r_sum <= n_sum;
                        if (r_idx < r_count) begin
                            r_fsm <= S_RD;
                        end else begin
                            r_status <= (n_sum > UTIL_W'(r_limit)) ? STS_REJECTED : STS_OK;
                            r_fsm    <= S_FIN;
                        end
                    end
                end

                S_RD: begin
                    r_raddr <= r_idx[SLOT_W-1:0];
                    r_fsm   <= S_WT;
                end

                S_WT: begin
                    r_fsm <= S_EV;
                end

                S_EV: begin
                    case (r_func)
                        FN_ADMIT: begin
                            r_prod <= PROD_W'(e.comp * UTIL_SCALE);
                            r_dvs  <= (e.period == '0) ? PER_W'(1) : e.period;
                            r_idx  <= r_idx + CNT_W'(1);
                            r_fsm  <= S_DST;
                        end
                        FN_DISPATCH: begin
                            if ((e.tstate inside {TS_READY, TS_RUNNING}) &&
                                (!r_cand_ok || e.period < r_cand_ent.period)) begin
                                r_cand_ok   <= 1'b1;
                                r_cand_slot <= r_idx[SLOT_W-1:0];
                                r_cand_ent  <= e;
                            end
                            if (r_run_pres && r_run_slot == r_idx[SLOT_W-1:0]) begin
                                r_run_ent <= e;
                            end
                            if (more) begin
                                r_idx <= r_idx + CNT_W'(1);
                                r_fsm <= S_RD;
                            end else begin
                                r_fsm <= S_DSP;
                            end
                        end
                        default: begin
                            if (e.id == r_id) begin
                                case (r_func)
                                    FN_WAKEUP: begin
                                        r_we       <= 1'b1;
                                        r_waddr    <= r_idx[SLOT_W-1:0];
                                        r_wdata    <= e;
                                        r_wdata.tstate <= TS_READY;
                                        r_fsm      <= S_FIN;
                                    end
                                    FN_YIELD: begin
                                        r_we    <= 1'b1;
                                        r_waddr <= r_idx[SLOT_W-1:0];
                                        r_wdata <= e;
                                        if (r_now < e.rel_tick) begin
                                            r_wdata.tstate <= TS_SLEEPING;
                                            r_arm <= 1'b1;
                                            r_exp <= e.rel_tick;
                                            if (r_run_slot == r_idx[SLOT_W-1:0]) begin
                                                r_run_pres <= 1'b0;
                                            end
                                        end else begin
                                            if (e.tstate == TS_SLEEPING) begin
                                                r_wdata.tstate <= TS_READY;
                                            end
                                            r_run_pres <= 1'b0;
                                        end
                                        r_fsm <= S_FIN;
                                    end
                                    default: begin
                                        // deregister: fix the running slot, then close the gap
                                        if (r_run_pres) begin
                                            if (r_run_slot == r_idx[SLOT_W-1:0]) begin
                                                r_run_pres <= 1'b0;
                                            end else if (r_run_slot > r_idx[SLOT_W-1:0]) begin
                                                r_run_slot <= r_run_slot - SLOT_W'(1);
                                            end
                                        end
                                        r_fsm <= S_SH_RD;
                                    end
                                endcase
                            end else if (more) begin
                                r_idx <= r_idx + CNT_W'(1);
                                r_fsm <= S_RD;
                            end else begin
                                r_status <= STS_NOT_FOUND;
                                r_fsm    <= S_FIN;
                            end
                        end
                    endcase
                end

                S_SH_RD: begin
                    if (more) begin
                        r_raddr <= SLOT_W'(r_idx + CNT_W'(1));
                        r_fsm   <= S_SH_WT;
                    end else begin
                        r_count <= r_count - CNT_W'(1);
                        r_fsm   <= S_FIN;
                    end
                end

                S_SH_WT: begin
                    r_fsm <= S_SH_WR;
                end

                S_SH_WR: begin
                    r_we    <= 1'b1;
                    r_waddr <= r_idx[SLOT_W-1:0];
                    r_wdata <= e;
                    r_idx   <= r_idx + CNT_W'(1);
                    r_fsm   <= S_SH_RD;
                end

                S_DSP: begin
                    r_fsm <= S_FIN;
                    if (r_run_pres) begin
                        // preempt only on a strictly shorter period
                        if (r_cand_ok && r_cand_ent.period < r_run_ent.period) begin
                            r_we       <= 1'b1;
                            r_waddr    <= r_run_slot;
                            r_wdata    <= r_run_ent;
                            r_wdata.tstate <= TS_READY;
                            r_pre      <= 1'b1;
                            r_pre_id   <= r_run_ent.id;
                            r_run_pres <= 1'b0;
                            r_fsm      <= S_DSP2;
                        end
                    end else if (r_cand_ok) begin
                        r_fsm <= S_DSP2;
                    end
                end

                S_DSP2: begin
                    r_we       <= 1'b1;
                    r_waddr    <= r_cand_slot;
                    r_wdata    <= r_cand_ent;
                    r_wdata.tstate   <= TS_RUNNING;
                    r_wdata.rel_tick <= r_cand_ent.rel_tick + TICK_W'(r_cand_ent.period);
                    r_run_slot <= r_cand_slot;
                    r_run_pres <= 1'b1;
                    r_run_id   <= r_cand_ent.id;
                    r_sw       <= 1'b1;
                    r_fsm      <= S_FIN;
                end

                S_FIN: begin
                    // result register free or being drained this cycle
                    if (!r_ov || i_ready) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_status;
                        r_o_run_v  <= runp;
                        r_o_run_id <= runp ? r_run_id : '0;
                        r_o_sw     <= r_sw;
                        r_o_pre    <= r_pre;
                        r_o_pre_id <= r_pre_id;
                        r_o_arm    <= r_arm;
                        r_o_exp    <= r_exp;
                        r_o_util   <= (r_func == FN_ADMIT) ? r_sum : '0;
                        r_fsm      <= S_IDLE;
                    end
                end

                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready             = (r_fsm == S_IDLE);
    assign o_cfg_ready         = 1'b1;
    assign o_valid             = r_ov;
    assign o_status            = r_o_status;
    assign o_running_valid     = r_o_run_v;
    assign o_running_id        = r_o_run_id;
    assign o_switched          = r_o_sw;
    assign o_preempted         = r_o_pre;
    assign o_preempted_id      = r_o_pre_id;
    assign o_arm_timer         = r_o_arm;
    assign o_timer_expiry      = r_o_exp;
    assign o_utilization_total = r_o_util;

    `RMS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_TASKS), "task count over table size")
    `RMS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_ready, "second command taken while busy")
    `RMS_ASSERT_NOW(a_switch_runs, i_clk, i_rst_n, r_ov && r_o_sw, r_o_run_v, "switch reported with nothing running")
    `RMS_ASSERT_NOW(a_one_write, i_clk, i_rst_n, r_we, r_fsm != S_IDLE || r_func == FN_REGISTER || r_func == FN_WAKEUP || r_func == FN_YIELD || r_func == FN_DISPATCH || r_func == FN_DEREGISTER, "table write outside an update")
endmodule

// ===== sim/rms_checker.sv =====
module rms_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_ready,
    input  logic [2:0]                  i_func,
    input  logic [rms_pkg::ID_W-1:0]    i_task_id,
    input  logic [rms_pkg::PER_W-1:0]   i_task_period,
    input  logic [rms_pkg::COMP_W-1:0]  i_task_computation,
    input  logic [rms_pkg::TICK_W-1:0]  i_now_ticks,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [1:0]                  o_status,
    input  logic                        o_running_valid,
    input  logic [rms_pkg::ID_W-1:0]    o_running_id,
    input  logic                        o_switched,
    input  logic                        o_preempted,
    input  logic [rms_pkg::ID_W-1:0]    o_preempted_id,
    input  logic                        o_arm_timer,
    input  logic [rms_pkg::TICK_W-1:0]  o_timer_expiry,
    input  logic [rms_pkg::UTIL_W-1:0]  o_utilization_total,
    input  logic                        i_cfg_valid,
    input  logic                        o_cfg_ready,
    input  logic [rms_pkg::LIM_W-1:0]   i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rms_pkg::*;

    typedef struct packed {
        logic [1:0]        status;
        logic              run_valid;
        logic [ID_W-1:0]   run_id;
        logic              switched;
        logic              preempted;
        logic [ID_W-1:0]   pre_id;
        logic              arm;
        logic [TICK_W-1:0] expiry;
        logic [UTIL_W-1:0] util;
    } sched_result_t;

    sched_result_t     sched_expected_q[$];

    // shadow task table
    logic              tb_valid [MAX_TASKS];
    logic [ID_W-1:0]   tb_id    [MAX_TASKS];
    logic [PER_W-1:0]  tb_per   [MAX_TASKS];
    logic [COMP_W-1:0] tb_comp  [MAX_TASKS];
    logic [1:0]        tb_state [MAX_TASKS];
    logic [TICK_W-1:0] tb_rel   [MAX_TASKS];
    int                run_slot;
    logic              run_present;
    logic [LIM_W-1:0]  util_limit;

    assign o_pending = sched_expected_q.size();

    function automatic longint unsigned util_term(logic [COMP_W-1:0] c, logic [PER_W-1:0] p);
        longint unsigned d;
        d = (p == 0) ? 1 : p;
        return (longint'(c) * 1000) / d;
    endfunction

    function automatic int lookup_slot(logic [ID_W-1:0] id);
        for (int i = 0; i < MAX_TASKS; i++)
            if (tb_valid[i] && tb_id[i] == id) return i;
        return -1;
    endfunction

    task automatic schedule_op(input logic [2:0] fn, input logic [ID_W-1:0] id,
                               input logic [PER_W-1:0] per, input logic [COMP_W-1:0] comp,
                               input logic [TICK_W-1:0] now, output sched_result_t r);
        longint unsigned util;
        int k;
        int cand;
        r = '0;
        util = 0;
        if (!tb_valid[run_slot]) run_present = 1'b0;
        case (fn)
            FN_ADMIT: begin
                util = util_term(comp, per);
                for (int i = 0; i < MAX_TASKS; i++)
                    if (tb_valid[i]) util += util_term(tb_comp[i], tb_per[i]);
                if (util > util_limit) r.status = STS_REJECTED;
            end
            FN_REGISTER: begin
                k = -1;
                for (int i = 0; i < MAX_TASKS; i++)
                    if (!tb_valid[i] && k < 0) k = i;
                if (k < 0) begin
                    r.status = STS_FULL;
                end else begin
                    tb_valid[k] = 1'b1;
                    tb_id[k]    = id;
                    tb_per[k]   = per;
                    tb_comp[k]  = comp;
                    tb_state[k] = TS_SLEEPING;
                    tb_rel[k]   = now + TICK_W'(per);
                end
            end
            FN_DEREGISTER: begin
                k = lookup_slot(id);
                if (k < 0) begin
                    r.status = STS_NOT_FOUND;
                end else begin
                    if (run_present) begin
                        if (run_slot == k) run_present = 1'b0;
                        else if (run_slot > k) run_slot--;
                    end
                    for (int i = k; i + 1 < MAX_TASKS; i++) begin
                        tb_valid[i] = tb_valid[i+1];
                        tb_id[i]    = tb_id[i+1];
                        tb_per[i]   = tb_per[i+1];
                        tb_comp[i]  = tb_comp[i+1];
                        tb_state[i] = tb_state[i+1];
                        tb_rel[i]   = tb_rel[i+1];
                    end
                    tb_valid[MAX_TASKS-1] = 1'b0;
                end
            end
            FN_YIELD: begin
                if (run_present && tb_id[run_slot] == id) k = run_slot;
                else k = lookup_slot(id);
                if (k < 0) begin
                    r.status = STS_NOT_FOUND;
                end else if (now < tb_rel[k]) begin
                    tb_state[k] = TS_SLEEPING;
                    r.arm    = 1'b1;
                    r.expiry = tb_rel[k];
                    if (run_present && run_slot == k) run_present = 1'b0;
                end else begin
                    if (tb_state[k] == TS_SLEEPING) tb_state[k] = TS_READY;
                    run_present = 1'b0;
                end
            end
            FN_WAKEUP: begin
                k = lookup_slot(id);
                if (k < 0) r.status = STS_NOT_FOUND;
                else tb_state[k] = TS_READY;
            end
            FN_DISPATCH: begin
                cand = -1;
                for (int i = 0; i < MAX_TASKS; i++)
                    if (tb_valid[i] && (tb_state[i] == TS_READY || tb_state[i] == TS_RUNNING)
                        && (cand < 0 || tb_per[i] < tb_per[cand]))
                        cand = i;
                if (run_present) begin
                    if (cand >= 0 && tb_per[cand] < tb_per[run_slot]) begin
                        tb_state[run_slot] = TS_READY;
                        r.preempted = 1'b1;
                        r.pre_id    = tb_id[run_slot];
                        run_present = 1'b0;
                    end else begin
                        cand = -1;
                    end
                end
                if (cand >= 0 && !run_present) begin
                    run_slot       = cand;
                    run_present    = 1'b1;
                    tb_state[cand] = TS_RUNNING;
                    tb_rel[cand]   = tb_rel[cand] + TICK_W'(tb_per[cand]);
                    r.switched     = 1'b1;
                end
            end
            default: ;
        endcase
        r.run_valid = run_present;
        r.run_id    = run_present ? tb_id[run_slot] : '0;
        r.util      = (util > 65535) ? 16'hFFFF : UTIL_W'(util);
    endtask

    always @(posedge i_clk) begin
        sched_result_t exp_r;
        sched_result_t got;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                tb_valid[i] = 1'b0;
                tb_id[i] = '0; tb_per[i] = '0; tb_comp[i] = '0;
                tb_state[i] = TS_SLEEPING; tb_rel[i] = '0;
            end
            run_slot     = 0;
            run_present  = 1'b0;
            util_limit   = LIMIT_RESET;
            o_fail_count = 0;
            sched_expected_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) util_limit = i_cfg_data;
            if (i_valid && o_ready) begin
                schedule_op(i_func, i_task_id, i_task_period, i_task_computation,
                            i_now_ticks, exp_r);
                sched_expected_q.push_back(exp_r);
            end
            if (o_valid && i_ready) begin
                got = '{o_status, o_running_valid, o_running_id, o_switched, o_preempted,
                        o_preempted_id, o_arm_timer, o_timer_expiry, o_utilization_total};
                if (sched_expected_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_fail_count++;
                end else begin
                    exp_r = sched_expected_q.pop_front();
                    if (got.status != exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, got.status);
                        o_fail_count++;
                    end
                    if (got.run_valid != exp_r.run_valid) begin
                        $error("running_valid: expected %0d, got %0d",
                               exp_r.run_valid, got.run_valid);
                        o_fail_count++;
                    end
                    if (got.run_id != exp_r.run_id) begin
                        $error("running_id: expected %0h, got %0h", exp_r.run_id, got.run_id);
                        o_fail_count++;
                    end
                    if (got.switched != exp_r.switched) begin
                        $error("switched: expected %0d, got %0d", exp_r.switched, got.switched);
                        o_fail_count++;
                    end
                    if (got.preempted != exp_r.preempted) begin
                        $error("preempted: expected %0d, got %0d",
                               exp_r.preempted, got.preempted);
                        o_fail_count++;
                    end
                    if (got.pre_id != exp_r.pre_id) begin
                        $error("preempted_id: expected %0h, got %0h", exp_r.pre_id, got.pre_id);
                        o_fail_count++;
                    end
                    if (got.arm != exp_r.arm) begin
                        $error("arm_timer: expected %0d, got %0d", exp_r.arm, got.arm);
                        o_fail_count++;
                    end
                    if (got.expiry != exp_r.expiry) begin
                        $error("timer_expiry: expected %0h, got %0h", exp_r.expiry, got.expiry);
                        o_fail_count++;
                    end
                    if (got.util != exp_r.util) begin
                        $error("utilization_total: expected %0d, got %0d",
                               exp_r.util, got.util);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/rate_monotonic_scheduler_tb.sv =====
module rate_monotonic_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rms_pkg::*;

    // func codes the block does not decode
    localparam logic [2:0] FN_SPARE_6 = 3'd6;
    localparam logic [2:0] FN_SPARE_7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [2:0]          i_func = '0;
    logic [ID_W-1:0]     i_task_id = '0;
    logic [PER_W-1:0]    i_task_period = '0;
    logic [COMP_W-1:0]   i_task_computation = '0;
    logic [TICK_W-1:0]   i_now_ticks = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [1:0]          o_status;
    logic                o_running_valid;
    logic [ID_W-1:0]     o_running_id;
    logic                o_switched;
    logic                o_preempted;
    logic [ID_W-1:0]     o_preempted_id;
    logic                o_arm_timer;
    logic [TICK_W-1:0]   o_timer_expiry;
    logic [UTIL_W-1:0]   o_utilization_total;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [LIM_W-1:0]    i_cfg_data = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    // run control shared between the stimulus and the receiver
    bit no_idle   = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    // timebase and id pool for well-formed traffic
    logic [TICK_W-1:0] sim_now = '0;
    logic [ID_W-1:0]   id_pool [8];

    rate_monotonic_scheduler dut (.*);

    rms_checker u_checker (
        .*,
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random ready bursts, one long hold-off on request
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // one command transfer, then maybe a gap with valid low
    task automatic send_cmd(input logic [2:0] fn, input logic [ID_W-1:0] id,
                            input logic [PER_W-1:0] per, input logic [COMP_W-1:0] comp,
                            input logic [TICK_W-1:0] now);
        i_valid            <= 1'b1;
        i_func             <= fn;
        i_task_id          <= id;
        i_task_period      <= per;
        i_task_computation <= comp;
        i_now_ticks        <= now;
        do @(posedge i_clk); while (!o_ready);
        if (!no_idle && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // limit write, only with nothing in flight
    task automatic write_limit(input logic [LIM_W-1:0] value);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // one random command; mostly pool ids and a slowly advancing clock
    task automatic random_cmd();
        logic [2:0]        fn;
        logic [ID_W-1:0]   id;
        logic [PER_W-1:0]  per;
        logic [COMP_W-1:0] comp;
        logic [TICK_W-1:0] now;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)      fn = FN_ADMIT;
        else if (sel < 35) fn = FN_REGISTER;
        else if (sel < 47) fn = FN_DEREGISTER;
        else if (sel < 62) fn = FN_YIELD;
        else if (sel < 77) fn = FN_WAKEUP;
        else if (sel < 97) fn = FN_DISPATCH;
        else               fn = (sel == 97) ? FN_SPARE_6 : FN_SPARE_7;
        id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(0, 7)];
        case ($urandom_range(0, 9))
            0:       per = PER_W'($urandom);
            1:       per = '0;
            default: per = PER_W'($urandom_range(1, 200));
        endcase
        comp = ($urandom_range(0, 7) == 0) ? COMP_W'($urandom) : COMP_W'($urandom_range(0, 100));
        sim_now = sim_now + $urandom_range(0, 60);
        now = ($urandom_range(0, 19) == 0) ? TICK_W'($urandom) : sim_now;
        if (fn == FN_ADMIT || fn == FN_SPARE_6 || fn == FN_SPARE_7)
            now = ($urandom_range(0, 1) == 0) ? TICK_W'($urandom) : now;
        send_cmd(fn, id, per, comp, now);
    endtask

    task automatic new_id_pool();
        for (int i = 0; i < 8; i++) id_pool[i] = ID_W'($urandom);
        id_pool[0] = '0;
        id_pool[1] = '1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, wrap of release, sleep and ready yields,
        // preemption, zero period, duplicates, spare funcs
        write_limit(LIM_W'(1000));
        send_cmd(FN_DISPATCH,   '0,         '0,          '0,          '0);
        send_cmd(FN_YIELD,      22'h12345,  '0,          '0,          '0);
        send_cmd(FN_ADMIT,      '0,         '0,          '1,          '1);
        send_cmd(FN_REGISTER,   '0,         20'd1,       '0,          '1);
        send_cmd(FN_REGISTER,   '1,         '1,          '1,          '0);
        send_cmd(FN_ADMIT,      '0,         20'd10,      20'd5,       '0);
        send_cmd(FN_WAKEUP,     '1,         '0,          '0,          '0);
        send_cmd(FN_DISPATCH,   '0,         '0,          '0,          32'd5);
        send_cmd(FN_WAKEUP,     '0,         '0,          '0,          32'd6);
        send_cmd(FN_DISPATCH,   '0,         '0,          '0,          32'd7);
        send_cmd(FN_DISPATCH,   '0,         '0,          '0,          32'd8);
        send_cmd(FN_YIELD,      '1,         '0,          '0,          '0);
        send_cmd(FN_YIELD,      '0,         '0,          '0,          '1);
        send_cmd(FN_REGISTER,   '0,         20'd3,       20'd2,       32'd100);
        send_cmd(FN_WAKEUP,     '0,         '0,          '0,          32'd101);
        send_cmd(FN_YIELD,      '0,         '0,          '0,          32'd200);
        send_cmd(FN_DISPATCH,   '0,         '0,          '0,          32'd201);
        send_cmd(FN_DEREGISTER, '0,         '0,          '0,          32'd202);
        send_cmd(FN_DEREGISTER, 22'h2aaaaa, '0,          '0,          32'd203);
        send_cmd(FN_WAKEUP,     22'h155555, '0,          '0,          32'd204);
        send_cmd(FN_SPARE_6,    '1,         '1,          '1,          '1);
        send_cmd(FN_SPARE_7,    '0,         '0,          '0,          '0);
        send_cmd(FN_ADMIT,      '0,         '1,          '0,          '0);
        send_cmd(FN_DEREGISTER, '0,         '0,          '0,          '0);
        send_cmd(FN_DEREGISTER, '1,         '0,          '0,          '0);

        // random phases across limit settings; reset value is the first
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_limit(LIMIT_RESET);
                1: write_limit('0);
                2: write_limit(LIM_W'(1000));
                default: write_limit(LIM_W'($urandom_range(0, 1023)));
            endcase
            new_id_pool();
            sim_now = TICK_W'($urandom);
            for (int n = 0; n < 132; n++) begin
                // block fills up behind the held-off receiver
                if (ph == 1 && n == 40) hold_req = 1'b1;
                if (ph == 3 && n == 72) no_idle = 1'b1;
                random_cmd();
            end
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (700) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
